>>> hdl/asgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_pkg
// shared types and constants of the sgr color filter
// ----------------------------------------------------------------------------
package asgr_pkg;

    localparam int unsigned ATTR_W = 16;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned CODE_W = 13;   // signed decimal value of two parameter bytes

    // parse modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_CSI  = 2'd2;

    // special characters
    localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_M      = 8'h6D;

    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
    localparam logic [ATTR_W-1:0] BG_MASK   = 16'h00F0;
    localparam logic [2:0]        COLOR_WHITE = 3'd7;

    // result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_ATTR = 1'b1;

    // action decoded from a terminated sequence
    typedef struct packed {
        logic       set_int;
        logic       clr_int;
        logic       load_init;
        logic       load_color;
        logic [2:0] color;
    } t_sgr_action;

    // one step result of the parser
    typedef struct packed {
        logic                 has;
        logic                 kind;
        logic [CHAR_W-1:0]    ch;
        logic [ATTR_W-1:0]    attr;
    } t_result;

    // ansi color index to console bit order (bit0 blue, bit1 green, bit2 red)
    function automatic logic [2:0] ansi_to_console(input logic [2:0] idx);
        return {idx[0], idx[1], idx[2]};
    endfunction

endpackage

>>> hdl/asgr_code_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_code_decode
// turns the stored parameter bytes into a color / intensity action
// ----------------------------------------------------------------------------
module asgr_code_decode
    import asgr_pkg::*;
(
    input  logic [CHAR_W-1:0] i_p0,
    input  logic [CHAR_W-1:0] i_p1,
    input  logic [1:0]        i_pcnt,
    output t_sgr_action       o_action
);

    logic signed [CODE_W-1:0] d0;
    logic signed [CODE_W-1:0] d1;
    logic signed [CODE_W-1:0] code;
    logic signed [CODE_W-1:0] idx_full;

    assign d0 = $signed({{(CODE_W-CHAR_W){1'b0}}, i_p0}) -
                $signed({{(CODE_W-CHAR_W){1'b0}}, CH_ZERO});
    assign d1 = $signed({{(CODE_W-CHAR_W){1'b0}}, i_p1}) -
                $signed({{(CODE_W-CHAR_W){1'b0}}, CH_ZERO});

    // times ten as shift and add
    always_comb begin
        case (i_pcnt)
            2'd0:    code = '0;
            2'd1:    code = d0;
            default: code = (d0 <<< 3) + (d0 <<< 1) + d1;
        endcase
    end

    assign idx_full = code - 13'sd30;

    always_comb begin
        o_action = '0;
        case (code) inside
            13'sd0: begin
                o_action.clr_int   = 1'b1;
                o_action.load_init = 1'b1;
            end
            13'sd1: begin
                o_action.set_int = 1'b1;
            end
            [13'sd30:13'sd37]: begin
                o_action.load_color = 1'b1;
                o_action.color      = ansi_to_console(idx_full[2:0]);
            end
            13'sd90: begin
                o_action.load_color = 1'b1;
                o_action.color      = COLOR_WHITE;
                o_action.clr_int    = 1'b1;
            end
            default: begin
                o_action = '0;
            end
        endcase
    end

endmodule

>>> hdl/asgr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asgr_parser
// escape sequence state and the per-byte step logic
// ----------------------------------------------------------------------------
module asgr_parser
    import asgr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [CHAR_W-1:0] i_byte,
    input  logic              i_eos,
    input  logic [ATTR_W-1:0] i_init_attr,
    output t_result           o_result
);

    logic [1:0]        r_mode,  n_mode;
    logic [CHAR_W-1:0] r_p0,    n_p0;
    logic [CHAR_W-1:0] r_p1,    n_p1;
    logic [1:0]        r_pcnt,  n_pcnt;
    logic [ATTR_W-1:0] r_fore,  n_fore;
    logic              r_int,   n_int;

    t_sgr_action       action;
    logic [ATTR_W-1:0] upd_fore;
    logic              upd_int;

    asgr_code_decode u_code_decode (
        .i_p0     (r_p0),
        .i_p1     (r_p1),
        .i_pcnt   (r_pcnt),
        .o_action (action)
    );

    always_comb begin
        if (action.load_init) begin
            upd_fore = i_init_attr;
        end else if (action.load_color) begin
            upd_fore = {{(ATTR_W-3){1'b0}}, action.color};
        end else begin
            upd_fore = r_fore;
        end
        if (action.set_int) begin
            upd_int = 1'b1;
        end else if (action.clr_int) begin
            upd_int = 1'b0;
        end else begin
            upd_int = r_int;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_p0     = r_p0;
        n_p1     = r_p1;
        n_pcnt   = r_pcnt;
        n_fore   = r_fore;
        n_int    = r_int;
        o_result = '0;
        if (i_eos) begin
            o_result.has  = 1'b1;
            o_result.kind = KIND_ATTR;
            o_result.attr = i_init_attr;
        end else if (i_byte == CH_ESC) begin
            n_mode = MODE_ESC;
        end else if (r_mode == MODE_ESC && i_byte == CH_LBRACK) begin
            n_mode = MODE_CSI;
        end else if (r_mode == MODE_CSI) begin
            if (i_byte != CH_M) begin
                // bytes past the second are dropped
                if (r_pcnt == 2'd0) begin
                    n_p0   = i_byte;
                    n_pcnt = 2'd1;
                end else if (r_pcnt == 2'd1) begin
                    n_p1   = i_byte;
                    n_pcnt = 2'd2;
                end
            end else begin
                n_fore        = upd_fore;
                n_int         = upd_int;
                n_p0          = '0;
                n_p1          = '0;
                n_pcnt        = '0;
                n_mode        = MODE_IDLE;
                o_result.has  = 1'b1;
                o_result.kind = KIND_ATTR;
                o_result.attr = upd_fore | {{(ATTR_W-4){1'b0}}, upd_int, 3'b000}
                                | (i_init_attr & BG_MASK);
            end
        end else begin
            o_result.has  = 1'b1;
            o_result.kind = KIND_CHAR;
            o_result.ch   = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_p0   <= '0;
            r_p1   <= '0;
            r_pcnt <= '0;
            r_fore <= '0;
            r_int  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_p0   <= n_p0;
            r_p1   <= n_p1;
            r_pcnt <= n_pcnt;
            r_fore <= n_fore;
            r_int  <= n_int;
        end
    end

endmodule

>>> hdl/ansi_sgr_color_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_color_filter_unit
// strips ESC [ p m color sequences from a byte stream into attribute beats
// ----------------------------------------------------------------------------
// Takes one byte beat per cycle unless a result waits on a stalled output,
// and gives zero or one result beat for it: plain characters pass through
// (kind 0), a terminating 'm' or an end-of-stream beat gives a console
// attribute word (kind 1), and ESC, '[' and parameter bytes give nothing.
// The byte sits in an input register; one decode pass updates the parse
// state and fills the result register, and that single pass sets the rate.
// Beats with no result never wait on the output side. The user must write
// the initial attribute register only while the block is idle (unenforced).
// ----------------------------------------------------------------------------
module ansi_sgr_color_filter_unit
    import asgr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [ATTR_W-1:0] i_cfg_wdata,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CHAR_W-1:0] i_in_byte,
    input  logic              i_end_of_stream,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_result_kind,
    output logic [CHAR_W-1:0] o_out_char,
    output logic [ATTR_W-1:0] o_attribute
);

    // initial attribute, background nibble source
    logic [ATTR_W-1:0] r_cfg;

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_byte;
    logic              r_in_eos;

    // result register
    logic              r_out_valid;
    logic              r_out_kind;
    logic [CHAR_W-1:0] r_out_char;
    logic [ATTR_W-1:0] r_out_attr;

    t_result           step_res;
    logic              advance;
    logic              in_accept;

    asgr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_eos       (r_in_eos),
        .i_init_attr (r_cfg),
        .o_result    (step_res)
    );

    // a held byte moves on when it has no result or the result slot frees up
    assign advance    = r_in_valid &&
                        (!step_res.has || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 16'h0007;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_res.has) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.has) begin
            r_out_kind <= step_res.kind;
            r_out_char <= step_res.ch;
            r_out_attr <= step_res.attr;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_out_char    = r_out_char;
    assign o_attribute   = r_out_attr;

`ifndef NO_ASSERTIONS
    // a passed character carries no attribute bits
    a_char_no_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_CHAR) |-> (o_attribute == '0))
        else $error("character beat with nonzero attribute");

    // an attribute beat carries no character
    a_attr_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_ATTR) |-> (o_out_char == '0))
        else $error("attribute beat with nonzero character");

    // end of stream restores the initial attribute
    a_eos_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_eos) |=>
            (o_out_valid && o_result_kind == KIND_ATTR && o_attribute == $past(r_cfg)))
        else $error("end of stream did not give initial attribute");

    // stall toward the source only while a byte is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && step_res.has && r_out_valid))
        else $error("input stalled with nothing held");
`endif

endmodule

>>> tb/sv/ansi_sgr_color_filter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_color_filter_unit_tb
// self-checking regression of the sgr color filter
// ----------------------------------------------------------------------------
// A byte stream goes in as beats: plain text, well-formed color sequences
// with random codes, broken sequences and end-of-stream marks. A software
// copy of the parser predicts the beat that each byte gives, if any, and a
// checker compares every output beat with the oldest prediction. The run
// covers several initial attribute settings, random idling on both sides, a
// stretch with no idling, and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module ansi_sgr_color_filter_unit_tb
    import asgr_pkg::*;
();

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 4;
    localparam int PIPE_SETTLE  = 4;      // block latency plus margin
    localparam int END_SETTLE   = 10;
    localparam int HOLD_CYCLES  = 300;    // long output hold-off
    localparam int STUCK_LIMIT  = 3000;   // cycles with no beat moving
    localparam int IDLE_PCT     = 26;

    // sgr codes that the parser acts on
    localparam int SGR_RESET   = 0;
    localparam int SGR_BOLD    = 1;
    localparam int SGR_FG_LOW  = 30;
    localparam int SGR_FG_HIGH = 37;
    localparam int SGR_WHITE   = 90;
    localparam int SGR_CODES [11] = '{SGR_RESET, SGR_BOLD, 30, 31, 32, 33, 34, 35, 36,
                                      SGR_FG_HIGH, SGR_WHITE};

    // ansi color index to console order (bit0 blue, bit1 green, bit2 red)
    localparam logic [2:0] CONSOLE_ORDER [8] = '{3'd0, 3'd4, 3'd2, 3'd6,
                                                 3'd1, 3'd5, 3'd3, 3'd7};
    localparam logic [ATTR_W-1:0] INIT_ATTR_RESET = 16'd7;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
    } t_filter_beat;

    // dut ports
    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_we        = 1'b0;
    logic [ATTR_W-1:0] i_cfg_wdata     = '0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_stall;
    logic [CHAR_W-1:0] i_in_byte       = '0;
    logic              i_end_of_stream = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall     = 1'b0;
    logic              o_result_kind;
    logic [CHAR_W-1:0] o_out_char;
    logic [ATTR_W-1:0] o_attribute;

    // parser copy used for prediction
    logic [ATTR_W-1:0] mdl_init_attr  = INIT_ATTR_RESET;
    logic [1:0]        mdl_mode       = MODE_IDLE;
    logic [CHAR_W-1:0] mdl_pchars [2] = '{8'd0, 8'd0};
    logic [1:0]        mdl_pcount     = 2'd0;
    logic [ATTR_W-1:0] mdl_fore       = '0;
    logic              mdl_intensity  = 1'b0;

    t_filter_beat filter_out_q [$];
    int           fail_count  = 0;
    int           beats_sent  = 0;
    int           tx_idle_pct = IDLE_PCT;
    int           rx_idle_pct = IDLE_PCT;
    int           hold_seq    = 0;
    int           hold_seen   = 0;
    int           hold_left   = 0;
    int           stuck_count = 0;
    bit           tx_active   = 1'b0;

    ansi_sgr_color_filter_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_out_char      (o_out_char),
        .o_attribute     (o_attribute)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // predicts the beat for one accepted byte; returns 0 when none is due
    function automatic bit filter_predict(input logic [CHAR_W-1:0] b, input logic eos,
                                          output t_filter_beat r);
        int code;
        r = '0;
        // end of stream restores the initial attribute, state untouched
        if (eos) begin
            r.kind = KIND_ATTR;
            r.attr = mdl_init_attr;
            return 1'b1;
        end
        // ESC restarts a sequence from any mode, parameters kept
        if (b == CH_ESC) begin
            mdl_mode = MODE_ESC;
            return 1'b0;
        end
        if (mdl_mode == MODE_ESC && b == CH_LBRACK) begin
            mdl_mode = MODE_CSI;
            return 1'b0;
        end
        if (mdl_mode == MODE_CSI) begin
            // parameter bytes past the second are dropped
            if (b != CH_M) begin
                if (mdl_pcount < 2) begin
                    mdl_pchars[mdl_pcount] = b;
                    mdl_pcount++;
                end
                return 1'b0;
            end
            // every byte counts as a digit, even a non-digit one
            case (mdl_pcount)
                2'd0: code = SGR_RESET;
                2'd1: code = int'(mdl_pchars[0]) - int'(CH_ZERO);
                default: code = (int'(mdl_pchars[0]) - int'(CH_ZERO)) * 10
                                + (int'(mdl_pchars[1]) - int'(CH_ZERO));
            endcase
            if (code == SGR_BOLD) begin
                mdl_intensity = 1'b1;
            end else if (code == SGR_RESET) begin
                mdl_intensity = 1'b0;
                mdl_fore      = mdl_init_attr;
            end else if (code >= SGR_FG_LOW && code <= SGR_FG_HIGH) begin
                mdl_fore = {13'd0, CONSOLE_ORDER[code - SGR_FG_LOW]};
            end else if (code == SGR_WHITE) begin
                mdl_fore      = {13'd0, COLOR_WHITE};
                mdl_intensity = 1'b0;
            end
            // unknown codes keep color and intensity but still emit
            r.kind = KIND_ATTR;
            r.attr = mdl_fore | (ATTR_W'(mdl_intensity) << 3) | (mdl_init_attr & BG_MASK);
            mdl_pcount    = 2'd0;
            mdl_pchars[0] = '0;
            mdl_pchars[1] = '0;
            mdl_mode      = MODE_IDLE;
            return 1'b1;
        end
        // anything else passes through, the after-ESC mode included
        r.kind = KIND_CHAR;
        r.ch   = b;
        return 1'b1;
    endfunction

    // offers one beat with a random lead-in gap and holds it until accepted
    task automatic send_beat(input logic [CHAR_W-1:0] b, input logic eos);
        t_filter_beat r;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_byte       <= b;
        i_end_of_stream <= eos;
        tx_active = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (filter_predict(b, eos, r)) filter_out_q.push_back(r);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    endtask

    // ESC [ params m
    task automatic send_sgr(input string params);
        send_beat(CH_ESC, 1'b0);
        send_beat(CH_LBRACK, 1'b0);
        send_text(params);
        send_beat(CH_M, 1'b0);
    endtask

    // sender goes quiet until every predicted beat has come out
    task automatic drain_results();
        if (tx_active) begin
            i_in_valid <= 1'b0;
            tx_active = 1'b0;
        end
        while (filter_out_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_init_attr(input logic [ATTR_W-1:0] value);
        drain_results();
        // bytes that give no beat may still sit in the pipe
        repeat (PIPE_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_init_attr = value;
    endtask

    function automatic logic [CHAR_W-1:0] rand_param_byte();
        logic [CHAR_W-1:0] b;
        do b = CHAR_W'($urandom_range(255)); while (b == CH_ESC || b == CH_M);
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_digit();
        return CH_ZERO + CHAR_W'($urandom_range(9));
    endfunction

    // one random token: text, a well-formed sequence, a broken one or end mark
    task automatic send_random_token();
        logic [CHAR_W-1:0] params [$];
        int pick;
        int code;
        int n;
        pick = $urandom_range(99);
        if (pick < 35) begin
            send_beat(CHAR_W'($urandom_range(255)), 1'b0);
        end else if (pick < 85) begin
            case ($urandom_range(9))
                0: ;   // no parameters
                1, 2, 3, 4, 5: begin
                    code = SGR_CODES[$urandom_range(10)];
                    if (code >= 10) params.push_back(CH_ZERO + CHAR_W'(code / 10));
                    params.push_back(CH_ZERO + CHAR_W'(code % 10));
                end
                6, 7: begin
                    params.push_back(rand_digit());
                    params.push_back(rand_digit());
                end
                8: begin
                    n = $urandom_range(5, 3);
                    repeat (n) params.push_back(rand_digit());
                end
                default: begin
                    n = $urandom_range(2, 1);
                    repeat (n) params.push_back(rand_param_byte());
                end
            endcase
            send_beat(CH_ESC, 1'b0);
            send_beat(CH_LBRACK, 1'b0);
            foreach (params[i]) send_beat(params[i], 1'b0);
            send_beat(CH_M, 1'b0);
        end else if (pick < 95) begin
            case ($urandom_range(3))
                0: send_beat(CH_ESC, 1'b0);
                1: begin
                    send_beat(CH_ESC, 1'b0);
                    send_beat(rand_param_byte(), 1'b0);
                end
                2: begin
                    // sequence left unterminated for the next token to cut short
                    send_beat(CH_ESC, 1'b0);
                    send_beat(CH_LBRACK, 1'b0);
                    send_beat(rand_digit(), 1'b0);
                end
                default: send_beat($urandom_range(1) ? CH_M : CH_LBRACK, 1'b0);
            endcase
        end else begin
            send_beat(CHAR_W'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic report_mismatch(input string field, input int exp_v, input int act_v);
        fail_count++;
        $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
    endtask

    // ------------------------------------------------------------------------
    // test cases
    // ------------------------------------------------------------------------

    // byte extremes pass through, end mark gives the initial attribute
    task automatic test_passthrough_extremes();
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hFF, 1'b1);
    endtask

    // each code family under the current initial attribute
    task automatic test_sgr_codes();
        send_sgr("");       // empty parameter list acts as reset
        send_sgr("1");
        send_sgr("375");    // bytes past the second are dropped
        // stray byte after ESC passes and the ESC mode stays
        send_beat(CH_ESC, 1'b0);
        send_text("A[90m");
    endtask

    task automatic test_sequence_corners();
        // ESC inside a sequence keeps the first parameter, giving 34
        send_beat(CH_ESC, 1'b0);
        send_beat(CH_LBRACK, 1'b0);
        send_text("3");
        send_sgr("4");
        send_sgr("Z");      // non-digit byte gives a code that matches nothing
    endtask

    task automatic test_random_phase(input int n_beats, input logic [ATTR_W-1:0] attr,
                                     input int tx_pct, input int rx_pct);
        int stop_at;
        write_init_attr(attr);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) send_random_token();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    // long output hold-off while the sender keeps offering
    task automatic test_backpressure();
        write_init_attr(16'h00A5);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_seq++;
        repeat (40) send_beat(CHAR_W'($urandom_range(255)), 1'b0);
        send_sgr("32");
        send_sgr("0");
        // sender pause until the backlog is fully out
        drain_results();
        send_sgr("1");
        send_text("ok");
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stall, or a counted hold-off when one is requested
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // checker: every accepted output beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_beats
        t_filter_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (filter_out_q.size() == 0) begin
                fail_count++;
                $error("output beat with none predicted: kind %0d char 0x%0h attr 0x%0h",
                       o_result_kind, o_out_char, o_attribute);
            end else begin
                want = filter_out_q.pop_front();
                if (o_result_kind !== want.kind)
                    report_mismatch("result_kind", want.kind, o_result_kind);
                if (o_out_char !== want.ch)
                    report_mismatch("out_char", want.ch, o_out_char);
                if (o_attribute !== want.attr)
                    report_mismatch("attribute", want.attr, o_attribute);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when no beat moves for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_count = 0;
        else
            stuck_count++;
        if (stuck_count >= STUCK_LIMIT) begin
            $display("ansi_sgr_color_filter_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence of tests
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of the initial attribute is in effect here
        test_passthrough_extremes();
        test_sgr_codes();
        test_sequence_corners();

        // same corners under the register extremes
        write_init_attr(16'hFFFF);
        test_sgr_codes();
        test_passthrough_extremes();
        write_init_attr(16'h0000);
        test_sequence_corners();
        test_sgr_codes();

        test_random_phase(500, ATTR_W'($urandom_range(65535)), IDLE_PCT, IDLE_PCT);
        test_random_phase(300, 16'hFFFF, 0, 0);     // no idling at all
        test_backpressure();
        test_random_phase(200, 16'h0000, IDLE_PCT, IDLE_PCT);
        test_random_phase(250, ATTR_W'($urandom_range(65535)), IDLE_PCT, IDLE_PCT);

        drain_results();
        repeat (END_SETTLE) @(posedge i_clk);
        if (filter_out_q.size() != 0) begin
            fail_count++;
            $error("%0d predicted beats never came out", filter_out_q.size());
        end
        if (fail_count == 0) begin
            $display("ansi_sgr_color_filter_unit regression: pass");
        end else begin
            $display("ansi_sgr_color_filter_unit regression: fail");
        end
        $finish;
    end

endmodule
